// ===== rtl/mcpg_pkg.sv =====
// shared types, constants and codes of the memo cache with page generations
package mcpg_pkg;

   // cache geometry
   localparam int SLOT_COUNT    = 4096;
   localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
   localparam int PAGE_LIMIT    = 8192;
   localparam int PAGE_IDX_BITS = $clog2(PAGE_LIMIT);
   localparam int PAGE_BITS     = 12;
   localparam int CLR_DEPTH     = (SLOT_COUNT > PAGE_LIMIT) ? SLOT_COUNT : PAGE_LIMIT;
   localparam int CLR_BITS      = $clog2(CLR_DEPTH);

   // hash multipliers
   localparam logic [31:0] HASH_MUL_A = 32'h9E37_79B1;
   localparam logic [31:0] HASH_MUL_B = 32'h85EB_CA6B;
   localparam int HASH_SHIFT_A = 15;
   localparam int HASH_SHIFT_H = 7;
   localparam int HASH_SHIFT_B = 13;

   // opcodes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_FILL   = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAGES  = 2'd2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_PAGES_W = 14;
   localparam logic [CSR_PAGES_W-1:0] PAGES_RESET = CSR_PAGES_W'(8192);
   localparam logic [CSR_PAGES_W-1:0] PAGES_MAX   = CSR_PAGES_W'(PAGE_LIMIT);

   // stream widths
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic                   enable;
      logic [31:0]            base;
      logic [CSR_PAGES_W-1:0] pages;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]               op;
      logic [SLOT_BITS-1:0]     slot;
      logic [31:0]              addr;
      logic [31:0]              tword;
      logic [7:0]               hint;
      logic [31:0]              value;
      logic                     addr_ok;
      logic [PAGE_IDX_BITS-1:0] page;
      logic                     free_ok;
      logic [PAGE_IDX_BITS-1:0] fp0;
      logic [PAGE_IDX_BITS-1:0] fp1;
   } entry_type;

   typedef struct packed {
      logic clearing;
   } status_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key_addr;
      logic [31:0] key_time;
      logic [31:0] value;
      logic [31:0] gen;
      logic [7:0]  hint_in;
      logic [7:0]  hint_out;
   } slot_type;

endpackage

// ===== rtl/memo_cache_page_generation.sv =====
// top level of the memo cache with page generations
//
//  channel  | direction | contents
//  req_*    | in        | tuser: opcode; tdata: object, time, hint, value, free addr/size
//  rsp_*    | out       | tuser: hit; tdata: value_out, hint_out
//  csr_*    | in        | register writes: enable, region base, region pages
//
// a lookup or fill passes the two hash multiplies in the front end, the queue and
// the registered store reads; the front end takes a new request as it hands the last
// one on, and a free walks its pages in turn through the generation store port.
// after reset the stores are cleared while req_tready stays low.
// a stalled result holds the back end; the front end and queue keep taking items until the queue is full.
module memo_cache_page_generation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [167:0] req_tdata,  // object_addr, time_word, hint_now, value_in,
                                    // free_addr, free_size
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value_out, hint_out
   output logic [0:0]  rsp_tuser,   // hit
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   mcpg_pkg::cfg_type    cfg_ff;
   mcpg_pkg::status_type status;
   mcpg_pkg::entry_type  f_entry, b_entry;
   logic f_valid, f_ready, b_valid, b_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b1;
         cfg_ff.base   <= 32'd0;
         cfg_ff.pages  <= mcpg_pkg::PAGES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            mcpg_pkg::CSR_ENABLE: cfg_ff.enable <= csr_wdata[0];
            mcpg_pkg::CSR_BASE:   cfg_ff.base   <= csr_wdata;
            mcpg_pkg::CSR_PAGES:  cfg_ff.pages  <= csr_wdata[mcpg_pkg::CSR_PAGES_W-1:0];
            default: ;
         endcase
      end
   end

   mcpg_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .status(status),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .q_valid(f_valid), .q_ready(f_ready), .q_entry(f_entry)
   );

   mcpg_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_entry(f_entry),
      .out_valid(b_valid), .out_ready(b_ready), .out_entry(b_entry)
   );

   mcpg_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .status(status),
      .q_valid(b_valid), .q_ready(b_ready), .q_entry(b_entry),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule

// ===== rtl/mcpg_front.sv =====
// front end: accepts requests, hashes the key and locates pages
module mcpg_front (
   input  logic                clock,
   input  logic                reset,
   input  mcpg_pkg::cfg_type   cfg,
   input  mcpg_pkg::status_type status,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [mcpg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]          req_tuser,
   output logic                q_valid,
   input  logic                q_ready,
   output mcpg_pkg::entry_type q_entry
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_HASH = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  op_ff;
   logic [31:0] addr_ff, tword_ff, value_ff, faddr_ff, p1_ff, p2_ff;
   logic [7:0]  hint_ff;
   logic [32:0] end_ff;
   logic        size_nz_ff;
   logic        addr_ok_ff, free_ok_ff;
   logic [mcpg_pkg::PAGE_IDX_BITS-1:0] page_ff, fp0_ff, fp1_ff;

   logic        accept;
   logic [31:0] h0, h1, h2, mix, a_diff, f_diff;
   logic [32:0] e_diff;
   logic [mcpg_pkg::CSR_PAGES_W-1:0] use_pages;
   logic        a_ok, f_ok, e_ok;

   // handshake
   assign req_tready = !status.clearing &&
                       (state_ff == F_IDLE || (state_ff == F_PUSH && q_ready));
   assign accept  = req_tvalid && req_tready;
   assign q_valid = (state_ff == F_PUSH);

   // state sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (accept) state_in = F_HASH;
         F_HASH: state_in = F_PUSH;
         F_PUSH: begin
            if (accept) state_in = F_HASH;
            else if (q_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
   end

   // hash mixing before and after the second multiply
   assign h0 = addr_ff ^ p1_ff;
   assign h1 = h0 ^ (h0 >> mcpg_pkg::HASH_SHIFT_A);
   assign h2 = h1 ^ ({24'd0, hint_ff} << mcpg_pkg::HASH_SHIFT_H);
   assign mix = p2_ff ^ (p2_ff >> mcpg_pkg::HASH_SHIFT_B);

   // page location against the region
   assign use_pages = (cfg.pages > mcpg_pkg::PAGES_MAX) ? mcpg_pkg::PAGES_MAX : cfg.pages;
   assign a_diff = addr_ff - cfg.base;
   assign f_diff = faddr_ff - cfg.base;
   assign e_diff = end_ff - {1'b0, cfg.base};
   assign a_ok = (addr_ff >= cfg.base) &&
                 (33'(a_diff >> mcpg_pkg::PAGE_BITS) < 33'(use_pages));
   assign f_ok = size_nz_ff && (faddr_ff >= cfg.base) &&
                 (33'(f_diff >> mcpg_pkg::PAGE_BITS) < 33'(use_pages));
   assign e_ok = (end_ff >= {1'b0, cfg.base}) &&
                 (33'(e_diff >> mcpg_pkg::PAGE_BITS) < 33'(use_pages));

   // capture on transfer, first multiply straight from the port; second multiply and page location in the hash state
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_tuser;
         addr_ff    <= req_tdata[31:0];
         tword_ff   <= req_tdata[63:32];
         hint_ff    <= req_tdata[71:64];
         value_ff   <= req_tdata[103:72];
         faddr_ff   <= req_tdata[135:104];
         end_ff     <= {1'b0, req_tdata[135:104]} + {1'b0, req_tdata[167:136]} - 33'd1;
         size_nz_ff <= (req_tdata[167:136] != 32'd0);
         p1_ff      <= req_tdata[63:32] * mcpg_pkg::HASH_MUL_A;
      end
      if (state_ff == F_HASH) begin
         p2_ff      <= h2 * mcpg_pkg::HASH_MUL_B;
         addr_ok_ff <= a_ok;
         page_ff    <= mcpg_pkg::PAGE_IDX_BITS'(a_diff >> mcpg_pkg::PAGE_BITS);
         free_ok_ff <= f_ok;
         fp0_ff     <= mcpg_pkg::PAGE_IDX_BITS'(f_diff >> mcpg_pkg::PAGE_BITS);
         fp1_ff     <= e_ok ? mcpg_pkg::PAGE_IDX_BITS'(e_diff >> mcpg_pkg::PAGE_BITS)
                            : mcpg_pkg::PAGE_IDX_BITS'(use_pages - 1'b1);
      end
   end

   // classified item
   always_comb begin
      q_entry.op      = op_ff;
      q_entry.slot    = mix[mcpg_pkg::SLOT_BITS-1:0];
      q_entry.addr    = addr_ff;
      q_entry.tword   = tword_ff;
      q_entry.hint    = hint_ff;
      q_entry.value   = value_ff;
      q_entry.addr_ok = addr_ok_ff;
      q_entry.page    = page_ff;
      q_entry.free_ok = free_ok_ff;
      q_entry.fp0     = fp0_ff;
      q_entry.fp1     = fp1_ff;
   end

endmodule

// ===== rtl/mcpg_queue.sv =====
// two-entry queue between front and back
module mcpg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mcpg_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output mcpg_pkg::entry_type out_entry
);

   mcpg_pkg::entry_type store_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_entry = store_ff[rd_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= in_entry;
   end

endmodule

// ===== rtl/mcpg_back.sv =====
// back end: slot and generation stores, lookups, fills and page walks
module mcpg_back (
   input  logic                clock,
   input  logic                reset,
   input  mcpg_pkg::cfg_type   cfg,
   output mcpg_pkg::status_type status,
   input  logic                q_valid,
   output logic                q_ready,
   input  mcpg_pkg::entry_type q_entry,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [mcpg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]          rsp_tuser
);

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_WALK  = 2'd2;
   localparam logic [1:0] B_EXEC  = 2'd3;

   mcpg_pkg::slot_type slot_mem [mcpg_pkg::SLOT_COUNT];
   logic [31:0]        pg_mem   [mcpg_pkg::PAGE_LIMIT];

   logic [1:0]                         state_ff, state_in;
   logic [mcpg_pkg::CLR_BITS-1:0]      clr_ff;
   mcpg_pkg::entry_type                cur_ff;
   logic [mcpg_pkg::PAGE_IDX_BITS-1:0] wpage_ff;
   logic [mcpg_pkg::SLOT_BITS-1:0]     pend_slot_ff;
   logic [7:0]                         pend_hint_ff;
   logic [31:0]                        pend_gen_ff;
   mcpg_pkg::slot_type                 slot_rd_ff;
   logic [31:0]                        pg_rd_ff;
   logic                               rsp_valid_ff;
   logic                               hit_ff;
   logic [31:0]                        value_ff;
   logic [7:0]                         hint_ff;

   logic                               pop, out_free, finish, track, match;
   logic                               slot_we, pg_we, pg_re;
   logic [mcpg_pkg::SLOT_BITS-1:0]     slot_wa;
   mcpg_pkg::slot_type                 slot_wd;
   logic [mcpg_pkg::PAGE_IDX_BITS-1:0] pg_wa, pg_ra;
   logic [31:0]                        pg_wd;

   assign status.clearing = (state_ff == B_CLEAR);
   assign pop      = (state_ff == B_IDLE) && q_valid;
   assign q_ready  = pop;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign finish   = (state_ff == B_EXEC) && out_free;

   // lookup decision
   assign track = cfg.enable && (cur_ff.addr != 32'd0) && cur_ff.addr_ok;
   assign match = slot_rd_ff.valid && (slot_rd_ff.key_addr == cur_ff.addr) &&
                  (slot_rd_ff.key_time == cur_ff.tword) &&
                  (slot_rd_ff.hint_in == cur_ff.hint) && (slot_rd_ff.gen == pg_rd_ff);

   // sequencing and store ports
   always_comb begin
      state_in = state_ff;
      slot_we  = 1'b0;
      slot_wa  = pend_slot_ff;
      slot_wd  = '0;
      pg_we    = 1'b0;
      pg_wa    = wpage_ff;
      pg_wd    = pg_rd_ff + 32'd1;
      pg_re    = 1'b0;
      pg_ra    = wpage_ff + 1'b1;
      case (state_ff)
         B_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff[mcpg_pkg::SLOT_BITS-1:0];
            pg_we   = 1'b1;
            pg_wa   = clr_ff[mcpg_pkg::PAGE_IDX_BITS-1:0];
            pg_wd   = 32'd0;
            if (clr_ff == mcpg_pkg::CLR_BITS'(mcpg_pkg::CLR_DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (pop) begin
               pg_re = 1'b1;
               pg_ra = (q_entry.op == mcpg_pkg::OP_FREE) ? q_entry.fp0 : q_entry.page;
               if (q_entry.op == mcpg_pkg::OP_FREE && q_entry.free_ok) state_in = B_WALK;
               else state_in = B_EXEC;
            end
         end
         B_WALK: begin
            pg_we = 1'b1;
            if (wpage_ff == cur_ff.fp1) state_in = B_EXEC;
            else pg_re = 1'b1;
         end
         B_EXEC: begin
            if (out_free) begin
               state_in = B_IDLE;
               if (cur_ff.op == mcpg_pkg::OP_FILL && cfg.enable) begin
                  slot_we          = 1'b1;
                  slot_wd.valid    = 1'b1;
                  slot_wd.key_addr = cur_ff.addr;
                  slot_wd.key_time = cur_ff.tword;
                  slot_wd.value    = cur_ff.value;
                  slot_wd.gen      = pend_gen_ff;
                  slot_wd.hint_in  = pend_hint_ff;
                  slot_wd.hint_out = cur_ff.hint;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // slot store
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      if (pop) slot_rd_ff <= slot_mem[q_entry.slot];
   end

   // page generation store
   always_ff @(posedge clock) begin
      if (pg_we) pg_mem[pg_wa] <= pg_wd;
      if (pg_re) pg_rd_ff <= pg_mem[pg_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         pend_slot_ff <= '0;
         pend_hint_ff <= 8'd0;
         pend_gen_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (finish && cur_ff.op == mcpg_pkg::OP_LOOKUP && track && !match) begin
            pend_slot_ff <= cur_ff.slot;
            pend_hint_ff <= cur_ff.hint;
            pend_gen_ff  <= pg_rd_ff;
         end
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // item in flight and result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff   <= q_entry;
         wpage_ff <= q_entry.fp0;
      end else if (state_ff == B_WALK) begin
         wpage_ff <= wpage_ff + 1'b1;
      end
      if (finish) begin
         hit_ff   <= 1'b0;
         value_ff <= 32'd0;
         hint_ff  <= cur_ff.hint;
         if (cur_ff.op == mcpg_pkg::OP_LOOKUP && track && match) begin
            hit_ff   <= 1'b1;
            value_ff <= slot_rd_ff.value;
            hint_ff  <= slot_rd_ff.hint_out;
         end else if (cur_ff.op == mcpg_pkg::OP_FILL) begin
            value_ff <= cur_ff.value;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {hint_ff, value_ff};
   assign rsp_tuser[0] = hit_ff;

endmodule

// ===== rtl/mcpg_checker.sv =====
// port-level checks of the memo cache, bound to the top level
module mcpg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // store clearing follows reset, so no request is taken
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during store clearing");

   // no result is offered right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule

bind memo_cache_page_generation mcpg_checker u_mcpg_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
